FILE: rtl/core/integer_to_ascii_digits_core_macros.svh
// Assertion macros for the integer to ASCII digits core.
// Used by the checker module; depends on clk and rst_n in the including scope.
`ifndef INTEGER_TO_ASCII_DIGITS_CORE_MACROS_SVH
`define INTEGER_TO_ASCII_DIGITS_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ITAD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ITAD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/itad_pkg.sv
// Package for the integer to ASCII digits core.
// Holds item types, format codes, sizes, characters and controller interface structs.
package itad_pkg;

    localparam int VALUE_W    = 64;
    localparam int NUM_DIGITS = 20;
    localparam int IDX_W      = $clog2(NUM_DIGITS);
    localparam int CNT_W      = $clog2(VALUE_W);

    localparam logic [IDX_W-1:0] IDX_TOP  = IDX_W'(NUM_DIGITS - 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_W - 1);

    localparam logic [1:0] FMT_SDEC = 2'd0;
    localparam logic [1:0] FMT_UDEC = 2'd1;
    localparam logic [1:0] FMT_LHEX = 2'd2;
    localparam logic [1:0] FMT_UHEX = 2'd3;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_LOW_A = 8'h61;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [3:0] RADIX_DEC  = 4'd10;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [1:0]         format;
    } in_item_t;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic dabble;
        logic skip;
        logic emit_sign;
        logic emit_digit;
    } itad_cmd_t;

    typedef struct packed {
        logic is_hex;
        logic conv_last;
        logic idx_zero;
        logic digit_zero;
        logic neg;
        logic out_free;
    } itad_status_t;

endpackage

FILE: rtl/core/integer_to_ascii_digits_core.sv
// Top level of the integer to ASCII digits core.
// Joins itad_ctrl and itad_dpath; depends on itad_pkg.
//
// An input item carries a 64-bit value and a 2-bit format code: signed decimal
// of the low 32 bits, unsigned decimal of all 64 bits, lowercase hex or
// uppercase hex. The block returns the text one character per output item,
// most significant first, with last set on the final character.
// Both channels use valid and ready; one item is taken at a time.
// Decimal formats run a shift-add-3 loop, one value bit per cycle; hex
// formats pass through it without shifting. A leading-zero digit pass then
// drops suppressed digits, and characters leave one per cycle through the
// output register while the receiver is ready.
// in_ready is high only while no item is being converted; it rises again
// as the final character enters the output register.
// If the receiver stalls, the output register holds its character and the
// block waits. Reset clears the controller and the output valid flag.
module integer_to_ascii_digits_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  itad_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output itad_pkg::out_item_t out_data
);
    import itad_pkg::*;

    itad_cmd_t    cmd;
    itad_status_t status;

    itad_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    itad_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

FILE: rtl/core/itad_ctrl.sv
// Controller state machine of the integer to ASCII digits core.
// Depends on itad_pkg for the command and status structs.
module itad_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  itad_pkg::itad_status_t status,
    output itad_pkg::itad_cmd_t    cmd
);
    import itad_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_CONVERT = 5'b00010,
        ST_SKIP    = 5'b00100,
        ST_SIGN    = 5'b01000,
        ST_EMIT    = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                if (status.is_hex)
                begin
                    state_next = ST_SKIP;
                end
                else
                begin
                    cmd.dabble = 1'b1;
                    if (status.conv_last)
                    begin
                        state_next = ST_SKIP;
                    end
                end
            end
            ST_SKIP:
            begin
                if (status.digit_zero && !status.idx_zero)
                begin
                    cmd.skip = 1'b1;
                end
                else if (status.neg)
                begin
                    state_next = ST_SIGN;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (status.out_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (status.idx_zero)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/itad_dpath.sv
// Datapath of the integer to ASCII digits core: shift-add-3 digit register,
// digit pointer and output register. Depends on itad_pkg.
module itad_dpath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  itad_pkg::in_item_t     in_data,
    input  itad_pkg::itad_cmd_t    cmd,
    output itad_pkg::itad_status_t status,
    output logic                   out_valid,
    input  logic                   out_ready,
    output itad_pkg::out_item_t    out_data
);
    import itad_pkg::*;

    logic [NUM_DIGITS-1:0][3:0] digits_reg, digits_next;
    logic [VALUE_W-1:0]         bin_reg, bin_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic                       neg_reg, neg_next;
    logic                       hex_reg, hex_next;
    logic                       upper_reg, upper_next;
    logic                       out_valid_reg, out_valid_next;
    out_item_t                  out_data_reg, out_data_next;

    logic [NUM_DIGITS-1:0][3:0] adj;
    logic [4*NUM_DIGITS-1:0]    adj_flat;
    logic [31:0]                low;
    logic [31:0]                mag32;
    logic                       load_neg;
    logic [3:0]                 cur_digit;
    logic [7:0]                 cur_char;
    logic                       out_free;

    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            adj[i] = (digits_reg[i] >= 4'd5) ? (digits_reg[i] + 4'd3) : digits_reg[i];
        end
        adj_flat = adj;
    end

    assign low      = in_data.value[31:0];
    assign load_neg = (in_data.format == FMT_SDEC) && low[31];
    assign mag32    = load_neg ? (32'd0 - low) : low;

    assign cur_digit = digits_reg[idx_reg];
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        if (cur_digit < RADIX_DEC)
        begin
            cur_char = CHAR_ZERO + {4'd0, cur_digit};
        end
        else
        begin
            cur_char = (upper_reg ? CHAR_UP_A : CHAR_LOW_A) + {4'd0, cur_digit - RADIX_DEC};
        end
    end

    always_comb
    begin
        digits_next    = digits_reg;
        bin_next       = bin_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        neg_next       = neg_reg;
        hex_next       = hex_reg;
        upper_next     = upper_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.load)
        begin
            hex_next   = in_data.format[1];
            upper_next = (in_data.format == FMT_UHEX);
            neg_next   = load_neg;
            cnt_next   = '0;
            idx_next   = IDX_TOP;
            if (in_data.format[1])
            begin
                digits_next = {{(4*NUM_DIGITS-VALUE_W){1'b0}}, in_data.value};
            end
            else
            begin
                digits_next = '0;
            end
            if (in_data.format == FMT_UDEC)
            begin
                bin_next = in_data.value;
            end
            else
            begin
                bin_next = {{(VALUE_W-32){1'b0}}, mag32};
            end
        end

        if (cmd.dabble)
        begin
            digits_next = {adj_flat[4*NUM_DIGITS-2:0], bin_reg[VALUE_W-1]};
            bin_next    = {bin_reg[VALUE_W-2:0], 1'b0};
            cnt_next    = cnt_reg + 1'b1;
        end

        if (cmd.skip)
        begin
            idx_next = idx_reg - 1'b1;
        end

        if (cmd.emit_sign)
        begin
            out_valid_next          = 1'b1;
            out_data_next.character = CHAR_MINUS;
            out_data_next.last      = 1'b0;
        end

        if (cmd.emit_digit)
        begin
            out_valid_next          = 1'b1;
            out_data_next.character = cur_char;
            out_data_next.last      = (idx_reg == '0);
            if (idx_reg != '0)
            begin
                idx_next = idx_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg   <= digits_next;
        bin_reg      <= bin_next;
        cnt_reg      <= cnt_next;
        idx_reg      <= idx_next;
        neg_reg      <= neg_next;
        hex_reg      <= hex_next;
        upper_reg    <= upper_next;
        out_data_reg <= out_data_next;
    end

    assign status.is_hex     = hex_reg;
    assign status.conv_last  = (cnt_reg == CNT_LAST);
    assign status.idx_zero   = (idx_reg == '0);
    assign status.digit_zero = (cur_digit == 4'd0);
    assign status.neg        = neg_reg;
    assign status.out_free   = out_free;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: rtl/core/itad_checker.sv
// Port-level checker for the integer to ASCII digits core, bound to the top level.
// Depends on itad_pkg and integer_to_ascii_digits_core_macros.svh.
`include "integer_to_ascii_digits_core_macros.svh"

module itad_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input itad_pkg::out_item_t out_data
);
    import itad_pkg::*;

    logic char_ok;
    logic in_take;
    logic out_stall;
    logic is_minus;

    assign char_ok = ((out_data.character >= 8'h30) && (out_data.character <= 8'h39))
                  || ((out_data.character >= 8'h61) && (out_data.character <= 8'h66))
                  || ((out_data.character >= 8'h41) && (out_data.character <= 8'h46))
                  || (out_data.character == CHAR_MINUS);

    assign in_take   = in_valid && in_ready;
    assign out_stall = out_valid && !out_ready;
    assign is_minus  = (out_data.character == CHAR_MINUS);

    `ITAD_ASSERT_NXT(a_out_hold, out_stall, out_valid && $stable(out_data), "stalled item changed")
    `ITAD_ASSERT_NXT(a_busy_after_accept, in_take, !in_ready, "input taken twice in a row")
    `ITAD_ASSERT_IMP(a_char_set, out_valid, char_ok, "character outside the digit set")
    `ITAD_ASSERT_IMP(a_minus_not_last, out_valid && is_minus, !out_data.last, "minus marked last")

endmodule

bind integer_to_ascii_digits_core itad_checker u_itad_checker (.*);

FILE: sim/itad_text_monitor.sv
// Watches both channels of integer_to_ascii_digits_core and predicts the text of each value.
// Compares each returned character with the expected one; depends on itad_pkg only.
`timescale 1ns / 1ps

module itad_text_monitor (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  itad_pkg::in_item_t  in_data,
    input  logic                out_valid,
    input  logic                out_ready,
    input  itad_pkg::out_item_t out_data,
    output int                  fail_count,
    output int                  pending,
    output int                  item_count,
    output int                  char_count,
    output int                  neg_count
);
    import itad_pkg::*;

    localparam int PRINT_CAP = 25;

    out_item_t char_q[$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
        item_count = 0;
        char_count = 0;
        neg_count  = 0;
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        begin
            if (fail_count < PRINT_CAP)
            begin
                $display("%0t ns: %s mismatch, got %h expected %h",
                         $realtime, what, got, want);
            end
            fail_count = fail_count + 1;
        end
    endtask

    function automatic void queue_text_of(input in_item_t item);
        logic [63:0] mag;
        logic [31:0] low;
        logic        neg;
        logic        is_dec;
        logic [3:0]  d;
        logic [7:0]  rev[NUM_DIGITS];
        out_item_t   c;
        int          n;
        begin
            neg    = 1'b0;
            mag    = item.value;
            is_dec = (item.format == FMT_SDEC) || (item.format == FMT_UDEC);
            if (item.format == FMT_SDEC)
            begin
                low = item.value[31:0];
                neg = low[31];
                mag = {32'd0, neg ? (~low + 32'd1) : low};
            end
            n = 0;
            do
            begin
                if (is_dec)
                begin
                    d   = 4'(mag % 64'd10);
                    mag = mag / 64'd10;
                end
                else
                begin
                    d   = mag[3:0];
                    mag = mag >> 4;
                end
                if (d < 4'd10)
                    rev[n] = CHAR_ZERO + 8'(d);
                else if (item.format == FMT_UHEX)
                    rev[n] = CHAR_UP_A + 8'(d) - 8'd10;
                else
                    rev[n] = CHAR_LOW_A + 8'(d) - 8'd10;
                n++;
            end
            while (mag != 64'd0 && n < NUM_DIGITS);
            if (neg)
            begin
                c.character = CHAR_MINUS;
                c.last      = 1'b0;
                char_q.push_back(c);
                neg_count = neg_count + 1;
            end
            for (int k = n - 1; k >= 0; k--)
            begin
                c.character = rev[k];
                c.last      = (k == 0);
                char_q.push_back(c);
            end
        end
    endfunction

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                queue_text_of(in_data);
                item_count = item_count + 1;
            end
            if (out_valid && out_ready)
            begin
                char_count = char_count + 1;
                if (char_q.size() == 0)
                begin
                    report_mismatch("unexpected character", out_data.character, 8'h00);
                end
                else
                begin
                    want = char_q.pop_front();
                    if (out_data.character !== want.character)
                        report_mismatch("character", out_data.character, want.character);
                    if (out_data.last !== want.last)
                        report_mismatch("last flag", 8'(out_data.last), 8'(want.last));
                end
            end
            pending <= char_q.size();
        end
    end

endmodule

FILE: sim/integer_to_ascii_digits_core_test.sv
// Stimulus and verdict for integer_to_ascii_digits_core, with itad_text_monitor beside it.
// Sends directed and random values in all four formats; depends on itad_pkg and the RTL.
`timescale 1ns / 1ps

module integer_to_ascii_digits_core_test;
    import itad_pkg::*;

    localparam int RANDOM_ITEMS = 190;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 120;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;
    logic      calm      = 1'b0;
    int        idle_cycles = 0;
    int        fail_count;
    int        pending;
    int        item_count;
    int        char_count;
    int        neg_count;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    integer_to_ascii_digits_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    itad_text_monitor text_mon (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .fail_count (fail_count),
        .pending    (pending),
        .item_count (item_count),
        .char_count (char_count),
        .neg_count  (neg_count)
    );

    always @(posedge clk)
    begin
        out_ready <= calm || ($urandom_range(0, 99) >= 20);
    end

    always @(posedge clk)
    begin
        if (rst_n && !((in_valid && in_ready) || (out_valid && out_ready)))
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Nothing moved for %0d cycles.", STALL_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
        else
        begin
            idle_cycles <= 0;
        end
    end

    task automatic send_item(input logic [63:0] value, input logic [1:0] format);
        in_item_t item;
        begin
            item.value  = value;
            item.format = format;
            while (!calm && $urandom_range(0, 99) < 20)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            in_data  <= item;
            do
                @(posedge clk);
            while (!in_ready);
        end
    endtask

    initial
    begin
        logic [63:0] value;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_item(64'd0, FMT_SDEC);
        send_item(64'd0, FMT_UDEC);
        send_item(64'd0, FMT_LHEX);
        send_item(64'd0, FMT_UHEX);
        send_item(64'h0000_0000_8000_0000, FMT_SDEC);
        send_item(64'h0000_0000_7FFF_FFFF, FMT_SDEC);
        send_item(64'h0000_0000_FFFF_FFFF, FMT_SDEC);
        send_item(64'hDEAD_BEEF_0000_0005, FMT_SDEC);
        send_item(64'hFFFF_FFFF_FFFF_FFFF, FMT_SDEC);
        send_item(64'hFFFF_FFFF_FFFF_FFFF, FMT_UDEC);
        send_item(64'hFFFF_FFFF_FFFF_FFFF, FMT_LHEX);
        send_item(64'hFFFF_FFFF_FFFF_FFFF, FMT_UHEX);
        send_item(64'd1, FMT_UDEC);
        send_item(64'd9, FMT_SDEC);
        send_item(64'd10, FMT_UDEC);
        send_item(64'd10_000_000_000_000_000_000, FMT_UDEC);
        send_item(64'h8000_0000_0000_0000, FMT_UDEC);
        send_item(64'hFEDC_BA98_7654_3210, FMT_LHEX);
        send_item(64'h0123_4567_89AB_CDEF, FMT_UHEX);
        send_item(64'd15, FMT_LHEX);
        send_item(64'd16, FMT_UHEX);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            calm  <= (i >= 70 && i < 120);
            value = {$urandom, $urandom} >> $urandom_range(0, 64);
            send_item(value, 2'($urandom_range(0, 3)));
        end
        in_valid <= 1'b0;
        calm     <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d values in four formats, %0d of them negative decimals.",
                 item_count, neg_count);
        $display("Checked %0d returned characters against the predicted text.", char_count);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
